// File: rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants
// Constants, operation codes and controller/datapath interface structs for the
// factorial, permutation and combination unit.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Largest accepted n; every product up to MAX_N! fits in 64 bits.
    localparam int MAX_N    = 20;
    localparam int FUNC_W   = 2;
    localparam int OPND_W   = 6;
    localparam int RESULT_W = 64;
    // Width of a valid operand once range checked (holds up to MAX_N).
    localparam int N_W      = $clog2(MAX_N + 1);
    // Divisor k'! with k' <= MAX_N / 2; 10! needs 22 bits.
    localparam int DEN_W    = 22;
    localparam int BIT_W    = $clog2(RESULT_W);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_FACT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PERM = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMB = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a request and set up the numerator product
        logic num_step;  // one multiply of the numerator product
        logic den_load;  // set up the denominator product
        logic den_step;  // one multiply of the denominator product
        logic div_step;  // one restoring division step
        logic store;     // move the result into the output register
    } fpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic steps_zero; // numerator product complete
        logic is_comb;    // valid combination request, division needed
        logic cnt_zero;   // denominator product complete
        logic bits_last;  // final division step
        logic out_busy;   // output register full and not being taken
    } fpc_status_t;

endpackage

// File: rtl/fpc_ctrl.sv
// ----------------------------------------------------------------------------
// fpc_ctrl: sequencing state machine
// Steps the shared datapath through the numerator product, then, for a combination,
// the denominator product and the restoring division, and hands the result to the output.
// ----------------------------------------------------------------------------
module fpc_ctrl
    import fpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  fpc_status_t status,
    output fpc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_NUM    = 5'b00010,
        ST_DEN    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                if (status.steps_zero) begin
                    if (status.is_comb) begin
                        cmd.den_load = 1'b1;
                        state_next   = ST_DEN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    cmd.num_step = 1'b1;
                end
            end
            ST_DEN: begin
                if (status.cnt_zero) begin
                    state_next = ST_DIV;
                end else begin
                    cmd.den_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.bits_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.store  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/fpc_datapath.sv
// ----------------------------------------------------------------------------
// fpc_datapath: operand checks, multipliers and divider
// Holds the product accumulator, the denominator, the restoring division
// remainder and the output register.
// ----------------------------------------------------------------------------
module fpc_datapath
    import fpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [OPND_W-1:0]   s_n_value,
    input  logic [OPND_W-1:0]   s_k_value,
    input  fpc_cmd_t            cmd,
    output fpc_status_t         status,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RESULT_W-1:0] m_result,
    output logic                m_error
);

    logic [RESULT_W-1:0] acc_reg;
    logic [RESULT_W-1:0] acc_next;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    den_next;
    logic [DEN_W:0]      rem_reg;
    logic [DEN_W:0]      rem_next;
    logic [N_W-1:0]      cnt_reg;
    logic [N_W-1:0]      cnt_next;
    logic [N_W-1:0]      steps_reg;
    logic [N_W-1:0]      steps_next;
    logic [N_W-1:0]      kk_reg;
    logic [N_W-1:0]      kk_next;
    logic [BIT_W-1:0]    bit_cnt_reg;
    logic [BIT_W-1:0]    bit_cnt_next;
    logic                err_reg;
    logic                err_next;
    logic                comb_reg;
    logic                comb_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [RESULT_W-1:0] out_result_reg;
    logic [RESULT_W-1:0] out_result_next;
    logic                out_error_reg;
    logic                out_error_next;

    // Request checks and choice of the shorter product for combination.
    logic                in_err;
    logic [OPND_W-1:0]   n_minus_k;
    logic [OPND_W-1:0]   k_eff;

    always_comb begin
        in_err = (s_n_value > OPND_W'(MAX_N))
              || ((s_func != FUNC_FACT) && (s_func != FUNC_PERM) && (s_func != FUNC_COMB))
              || ((s_func != FUNC_FACT) && (s_k_value > s_n_value));
        n_minus_k = s_n_value - s_k_value;
        if (s_func == FUNC_FACT) begin
            k_eff = s_n_value;
        end else if ((s_func == FUNC_COMB) && (n_minus_k < s_k_value)) begin
            k_eff = n_minus_k;
        end else begin
            k_eff = s_k_value;
        end
    end

    // One restoring division step: shift in the next dividend bit and subtract.
    logic [DEN_W:0] rem_shift;
    logic           rem_ge;

    always_comb begin
        rem_shift = {rem_reg[DEN_W-1:0], acc_reg[RESULT_W-1]};
        rem_ge    = (rem_shift >= {1'b0, den_reg});
    end

    // Datapath register updates under controller command.
    always_comb begin
        acc_next        = acc_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        steps_next      = steps_reg;
        kk_next         = kk_reg;
        bit_cnt_next    = bit_cnt_reg;
        err_next        = err_reg;
        comb_next       = comb_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        out_error_next  = out_error_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cmd.load) begin
            acc_next   = RESULT_W'(1);
            err_next   = in_err;
            comb_next  = (s_func == FUNC_COMB) && !in_err;
            cnt_next   = s_n_value[N_W-1:0];
            kk_next    = k_eff[N_W-1:0];
            steps_next = in_err ? '0 : k_eff[N_W-1:0];
        end

        if (cmd.num_step) begin
            acc_next   = RESULT_W'(acc_reg * RESULT_W'(cnt_reg));
            cnt_next   = cnt_reg - N_W'(1);
            steps_next = steps_reg - N_W'(1);
        end

        if (cmd.den_load) begin
            den_next     = DEN_W'(1);
            cnt_next     = kk_reg;
            rem_next     = '0;
            bit_cnt_next = '0;
        end

        if (cmd.den_step) begin
            den_next = DEN_W'(den_reg * DEN_W'(cnt_reg));
            cnt_next = cnt_reg - N_W'(1);
        end

        if (cmd.div_step) begin
            rem_next     = rem_ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            acc_next     = {acc_reg[RESULT_W-2:0], rem_ge};
            bit_cnt_next = bit_cnt_reg + BIT_W'(1);
        end

        if (cmd.store) begin
            out_valid_next  = 1'b1;
            out_result_next = err_reg ? '0 : acc_reg;
            out_error_next  = err_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        acc_reg        <= acc_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        steps_reg      <= steps_next;
        kk_reg         <= kk_next;
        bit_cnt_reg    <= bit_cnt_next;
        err_reg        <= err_next;
        comb_reg       <= comb_next;
        out_result_reg <= out_result_next;
        out_error_reg  <= out_error_next;
    end

    // Status back to the controller.
    always_comb begin
        status.steps_zero = (steps_reg == '0);
        status.is_comb    = comb_reg;
        status.cnt_zero   = (cnt_reg == '0);
        status.bits_last  = (bit_cnt_reg == {BIT_W{1'b1}});
        status.out_busy   = out_valid_reg && !m_ready;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;
    assign m_error  = out_error_reg;

endmodule

// File: rtl/factorial_permutation_combination.sv
// ----------------------------------------------------------------------------
// factorial_permutation_combination: n!, P(n,k) and C(n,k) unit
// Operation: a request runs a product of k' multiply steps (k' = n for factorial),
// and a combination adds a denominator product and the restoring division.
// Throughput: one request at a time; the datapath has a 5-bit by 64-bit multiply step
// and a 64-step restoring divider.
// Reset: synchronous, active low; clears the state machine and output valid.
// ----------------------------------------------------------------------------
module factorial_permutation_combination
    import fpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [OPND_W-1:0]   s_n_value,
    input  logic [OPND_W-1:0]   s_k_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RESULT_W-1:0] m_result,
    output logic                m_error
);

    fpc_cmd_t    cmd;
    fpc_status_t status;

    // Sequencer.
    fpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and output register.
    fpc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_func    (s_func),
        .s_n_value (s_n_value),
        .s_k_value (s_k_value),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .m_error   (m_error)
    );

endmodule

// File: tb/fpc_checker.sv
// ----------------------------------------------------------------------------
// fpc_checker: request and result checker for the counting unit
// Watches both channels of the factorial, permutation and combination unit.
// It works out the value and error flag of every accepted request, queues
// them in order, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module fpc_checker
    import fpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [OPND_W-1:0]   s_n_value,
    input  logic [OPND_W-1:0]   s_k_value,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [RESULT_W-1:0] m_result,
    input  logic                m_error,
    output int                  fail_count,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Value and error flag of one request.
    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic                error;
    } count_result_t;

    // Results still owed by the unit, oldest first.
    count_result_t expected_counts[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("%0t ns: MISMATCH: %s", $time, what);
        fail_count++;
    endtask

    // Product of the integers lo to hi inclusive; the empty product is 1.
    function automatic logic [RESULT_W-1:0] product_range(input int lo, input int hi);
        logic [RESULT_W-1:0] acc;
        acc = RESULT_W'(1);
        for (int v = lo; v <= hi; v++) begin
            acc = acc * RESULT_W'(v);
        end
        return acc;
    endfunction

    // Works out what the unit must return for one request.
    function automatic count_result_t counting_outcome(
        input logic [FUNC_W-1:0] func,
        input logic [OPND_W-1:0] n_value,
        input logic [OPND_W-1:0] k_value
    );
        count_result_t outcome;
        int            n;
        int            k;
        int            k_short;
        n = int'(n_value);
        k = int'(k_value);
        outcome = '0;
        if (n > MAX_N) begin
            outcome.error = 1'b1;
        end else if (func == FUNC_FACT) begin
            outcome.value = product_range(1, n);
        end else if (func == FUNC_PERM || func == FUNC_COMB) begin
            if (k > n) begin
                outcome.error = 1'b1;
            end else if (func == FUNC_PERM) begin
                outcome.value = product_range(n - k + 1, n);
            end else begin
                // The shorter of k and n-k gives the same coefficient.
                k_short = (n - k < k) ? n - k : k;
                outcome.value = product_range(n - k_short + 1, n) /
                                product_range(1, k_short);
            end
        end else begin
            outcome.error = 1'b1;
        end
        return outcome;
    endfunction

    // Compare each result with the oldest expectation, then queue new requests.
    always @(posedge aclk) begin
        count_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("result %0d error %0b with no request waiting",
                                              m_result, m_error));
                end else begin
                    want = expected_counts.pop_front();
                    if (m_result !== want.value) begin
                        report_mismatch($sformatf("result %0d, expected %0d",
                                                  m_result, want.value));
                    end
                    if (m_error !== want.error) begin
                        report_mismatch($sformatf("error %0b, expected %0b",
                                                  m_error, want.error));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_counts.push_back(counting_outcome(s_func, s_n_value, s_k_value));
            end
        end
        outstanding <= expected_counts.size();
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the factorial, permutation and combination unit
// Sends a directed set of requests covering the operand limits, every
// operation and every rejected case, then random requests in bursts while the
// result side stalls on its own pattern. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import fpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation code that the unit does not implement.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1350;
    localparam int SETTLE_CYCLES   = 100;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func;
    logic [OPND_W-1:0]   s_n_value;
    logic [OPND_W-1:0]   s_k_value;
    logic                m_valid;
    logic                m_ready;
    logic [RESULT_W-1:0] m_result;
    logic                m_error;
    int                  fail_count;
    int                  outstanding;

    factorial_permutation_combination dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_n_value (s_n_value),
        .s_k_value (s_k_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .m_error   (m_error)
    );

    fpc_checker fpc_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_n_value   (s_n_value),
        .s_k_value   (s_k_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .m_error     (m_error),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Clock, 10 ns period.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Presents one request and returns at the edge where it is accepted.
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [OPND_W-1:0] n_value,
                                input logic [OPND_W-1:0] k_value);
        s_valid   <= 1'b1;
        s_func    <= func;
        s_n_value <= n_value;
        s_k_value <= k_value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Waits until the checker holds no outstanding request.
    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Result side: stall pattern that changes mode after each run of random length.
    initial begin : receiver
        int mode;
        int run;
        int phase;
        m_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(50, 400);
            for (phase = 0; phase < run; phase++) begin
                @(posedge aclk);
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 1) == 1);
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 7) == 0);
                    end
                    default: begin
                        m_ready <= ((phase % 13) >= 9);
                    end
                endcase
            end
        end
    end

    // Request side: reset, directed requests, then random bursts.
    initial begin : stimulus
        int                burst_left;
        int                gap;
        int                kind;
        logic [FUNC_W-1:0] func;
        logic [OPND_W-1:0] n_value;
        logic [OPND_W-1:0] k_value;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_func    <= FUNC_FACT;
        s_n_value <= '0;
        s_k_value <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Factorial: empty product, largest n, n out of range, k ignored.
        send_request(FUNC_FACT, 6'd0, 6'd63);
        send_request(FUNC_FACT, 6'd20, 6'd0);
        send_request(FUNC_FACT, 6'd21, 6'd0);
        send_request(FUNC_FACT, 6'd63, 6'd63);
        send_request(FUNC_FACT, 6'd1, 6'd5);
        // Permutation: full and empty products, k above n, n out of range.
        send_request(FUNC_PERM, 6'd20, 6'd20);
        send_request(FUNC_PERM, 6'd20, 6'd0);
        send_request(FUNC_PERM, 6'd0, 6'd0);
        send_request(FUNC_PERM, 6'd5, 6'd6);
        send_request(FUNC_PERM, 6'd20, 6'd21);
        send_request(FUNC_PERM, 6'd63, 6'd0);
        send_request(FUNC_PERM, 6'd10, 6'd3);
        // Combination: middle, both ends, the swapped k and the error cases.
        send_request(FUNC_COMB, 6'd20, 6'd10);
        send_request(FUNC_COMB, 6'd20, 6'd0);
        send_request(FUNC_COMB, 6'd20, 6'd20);
        send_request(FUNC_COMB, 6'd0, 6'd0);
        send_request(FUNC_COMB, 6'd7, 6'd8);
        send_request(FUNC_COMB, 6'd20, 6'd63);
        send_request(FUNC_COMB, 6'd21, 6'd5);
        send_request(FUNC_COMB, 6'd20, 6'd19);
        send_request(FUNC_COMB, 6'd13, 6'd4);
        // The unused operation code is always rejected.
        send_request(FUNC_UNUSED, 6'd5, 6'd2);
        send_request(FUNC_UNUSED, 6'd0, 6'd0);
        send_request(FUNC_UNUSED, 6'd63, 6'd63);
        s_valid <= 1'b0;
        wait_drained();

        // Random requests: mostly well formed, the rest rejected or arbitrary.
        burst_left = 0;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == RANDOM_REQUESTS / 2) begin
                // Hold off until the unit has returned everything.
                s_valid <= 1'b0;
                wait_drained();
            end else if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    s_valid   <= 1'b0;
                    s_func    <= FUNC_W'($urandom_range(0, 3));
                    s_n_value <= OPND_W'($urandom_range(0, 63));
                    s_k_value <= OPND_W'($urandom_range(0, 63));
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;

            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                func    = FUNC_W'($urandom_range(0, 2));
                n_value = OPND_W'($urandom_range(0, MAX_N));
                k_value = (func == FUNC_FACT) ? OPND_W'($urandom_range(0, 63))
                                              : OPND_W'($urandom_range(0, int'(n_value)));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        func    = FUNC_UNUSED;
                        n_value = OPND_W'($urandom_range(0, 63));
                        k_value = OPND_W'($urandom_range(0, 63));
                    end
                    1: begin
                        func    = FUNC_W'($urandom_range(0, 2));
                        n_value = OPND_W'($urandom_range(MAX_N + 1, 63));
                        k_value = OPND_W'($urandom_range(0, 63));
                    end
                    2: begin
                        func    = $urandom_range(1, 2) == 1 ? FUNC_PERM : FUNC_COMB;
                        n_value = OPND_W'($urandom_range(0, MAX_N));
                        k_value = OPND_W'($urandom_range(int'(n_value) + 1, 63));
                    end
                    default: begin
                        func    = FUNC_W'($urandom_range(0, 3));
                        n_value = OPND_W'($urandom_range(0, 63));
                        k_value = OPND_W'($urandom_range(0, 63));
                    end
                endcase
            end
            send_request(func, n_value, k_value);
        end
        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
